// File: hw/rtl/ott_pkg.sv
// ott_pkg: shared types and constants of the one-shot timer table
// used by ott_ctrl, ott_dp and oneshot_timer_table; no dependencies
`default_nettype none

package ott_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ACTION_W  = 2;
  localparam int SLOT_ID_W = 4;
  localparam int TICKS_W   = 32;
  localparam int ELAPSED_W = 16;

  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [SLOT_ID_W-1:0] slot_id_t;
  typedef logic [TICKS_W-1:0]   ticks_t;
  typedef logic [ELAPSED_W-1:0] elapsed_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [SLOT_W:0]      slot_cnt_t;

  localparam action_t ACT_TICK   = 2'd0;
  localparam action_t ACT_ATTACH = 2'd1;
  localparam action_t ACT_DETACH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } ott_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic flush;
  } ott_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_req;
    logic at_end;
    logic blocked;
    logic flush_ok;
  } ott_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/oneshot_timer_table.sv
// oneshot_timer_table: top level of the one-shot timer table
// depends on ott_pkg, ott_ctrl and ott_dp
//
// Input channel (in_valid/in_stall) takes one item: tick, attach or detach.
// Result channel (out_valid/out_stall) returns one item per expired slot with
// notify set, oldest attached first; out_last marks the final one of a tick.
// Attach needs no walk. Detach of an armed slot and every tick walk the
// attach-order queue through a single compare and subtract, one armed slot
// per cycle unless a stalled receiver holds the walk, then close out through
// the end-of-queue check (ST_WALK) and the flush (ST_FLUSH). Detach of a free
// slot and unused codes need no walk either.
// One report is held back until the next is found so that the last can be
// marked; a finished result waits in the output register while the block
// goes on, and when the receiver stalls with a new report due the walk
// holds in place until the register frees. in_stall is high during a walk.
// Reset (rst_n low, synchronous) disarms all slots, empties the queue and
// drops any result not yet taken.
`default_nettype none

module oneshot_timer_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ott_pkg::action_t  in_action,
  input  wire ott_pkg::slot_id_t in_slot_id,
  input  wire ott_pkg::ticks_t   in_initial_ticks,
  input  wire logic              in_notify,
  input  wire ott_pkg::elapsed_t in_elapsed_ticks,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ott_pkg::slot_id_t      out_expired_slot,
  output logic                   out_last
);

  ott_pkg::ott_cmd_t cmd;
  ott_pkg::ott_sts_t sts;

  ott_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ott_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_slot_id       (in_slot_id),
    .in_initial_ticks (in_initial_ticks),
    .in_notify        (in_notify),
    .in_elapsed_ticks (in_elapsed_ticks),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_expired_slot (out_expired_slot),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ott_ctrl.sv
// ott_ctrl: sequencer of the one-shot timer table
// depends on ott_pkg; drives the datapath ott_dp through command and status structs
`default_nettype none

module ott_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ott_pkg::ott_sts_t sts,
  output ott_pkg::ott_cmd_t      cmd
);

  ott_pkg::ott_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ott_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.flush  = 1'b0;
    in_stall   = 1'b1;
    case (state_r)
      ott_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.walk_req) begin
          state_nxt = ott_pkg::ST_WALK;
        end
      end
      ott_pkg::ST_WALK: begin
        if (sts.at_end) begin
          state_nxt = ott_pkg::ST_FLUSH;
        end else begin
          cmd.step = !sts.blocked;
        end
      end
      ott_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_ok) begin
          state_nxt = ott_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ott_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ott_dp.sv
// ott_dp: slot store, age-ordered queue and result register of the timer table
// depends on ott_pkg; commanded by ott_ctrl
`default_nettype none

module ott_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ott_pkg::action_t  in_action,
  input  wire ott_pkg::slot_id_t in_slot_id,
  input  wire ott_pkg::ticks_t   in_initial_ticks,
  input  wire logic              in_notify,
  input  wire ott_pkg::elapsed_t in_elapsed_ticks,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ott_pkg::slot_id_t      out_expired_slot,
  output logic                   out_last,
  input  wire ott_pkg::ott_cmd_t cmd,
  output ott_pkg::ott_sts_t      sts
);

  // per-slot state
  logic [ott_pkg::SLOTS-1:0] armed_r;
  ott_pkg::ticks_t           rem_r [ott_pkg::SLOTS];
  logic [ott_pkg::SLOTS-1:0] ntf_r;

  // armed slots in attach order, oldest at index 0
  ott_pkg::slot_idx_t q_r [ott_pkg::SLOTS];
  ott_pkg::slot_cnt_t cnt_r;

  // walk pointers: read and compacted write position
  ott_pkg::slot_cnt_t rd_r;
  ott_pkg::slot_cnt_t wr_r;

  ott_pkg::elapsed_t  elapsed_r;
  ott_pkg::slot_idx_t tgt_r;
  logic               tick_r;

  // one report held back until we know whether it is the last
  logic               pend_v_r;
  ott_pkg::slot_idx_t pend_slot_r;

  logic               out_valid_r;
  ott_pkg::slot_idx_t out_slot_r;
  logic               out_last_r;

  ott_pkg::slot_idx_t in_idx;
  logic               in_slot_ok;
  logic               do_attach;
  ott_pkg::slot_idx_t cur_id;
  ott_pkg::ticks_t    cur_rem;
  logic               cur_exp;
  logic               cur_drop;
  logic               cur_emit;
  logic               out_free;
  logic               push_mid;
  logic               push_last;

  always_comb begin
    in_idx     = ott_pkg::slot_idx_t'(in_slot_id);
    in_slot_ok = 32'(in_slot_id) < 32'(ott_pkg::SLOTS);
    do_attach  = cmd.accept && (in_action == ott_pkg::ACT_ATTACH) && in_slot_ok &&
                 !armed_r[in_idx];

    cur_id   = q_r[rd_r[ott_pkg::SLOT_W-1:0]];
    cur_rem  = rem_r[cur_id];
    cur_exp  = cur_rem <= 32'(elapsed_r);
    cur_drop = tick_r ? cur_exp : (cur_id == tgt_r);
    cur_emit = tick_r && cur_exp && ntf_r[cur_id];

    out_free  = !out_valid_r || !out_stall;
    push_mid  = cmd.step && cur_emit && pend_v_r;
    push_last = cmd.flush && pend_v_r && out_free;

    sts.walk_req = (in_action == ott_pkg::ACT_TICK) ||
                   ((in_action == ott_pkg::ACT_DETACH) && in_slot_ok && armed_r[in_idx]);
    sts.at_end   = rd_r == cnt_r;
    sts.blocked  = cur_emit && pend_v_r && !out_free;
    sts.flush_ok = !pend_v_r || out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= '0;
      cnt_r       <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_attach) begin
        armed_r[in_idx] <= 1'b1;
        cnt_r           <= cnt_r + 1'b1;
      end else if (cmd.step && cur_drop) begin
        armed_r[cur_id] <= 1'b0;
      end

      if (cmd.accept) begin
        rd_r     <= '0;
        wr_r     <= '0;
        pend_v_r <= 1'b0;
      end else if (cmd.step) begin
        rd_r <= rd_r + 1'b1;
        if (!cur_drop) begin
          wr_r <= wr_r + 1'b1;
        end
        if (cur_emit) begin
          pend_v_r <= 1'b1;
        end
      end else if (cmd.flush && sts.flush_ok) begin
        cnt_r    <= wr_r;
        pend_v_r <= 1'b0;
      end

      if (push_mid || push_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      elapsed_r <= in_elapsed_ticks;
      tgt_r     <= in_idx;
      tick_r    <= in_action == ott_pkg::ACT_TICK;
    end
    if (do_attach) begin
      rem_r[in_idx]                      <= in_initial_ticks;
      ntf_r[in_idx]                      <= in_notify;
      q_r[cnt_r[ott_pkg::SLOT_W-1:0]]    <= in_idx;
    end
    if (cmd.step) begin
      if (!cur_drop) begin
        q_r[wr_r[ott_pkg::SLOT_W-1:0]] <= cur_id;
      end
      if (tick_r && !cur_exp) begin
        rem_r[cur_id] <= cur_rem - 32'(elapsed_r);
      end
      if (cur_emit) begin
        pend_slot_r <= cur_id;
      end
    end
    if (push_mid || push_last) begin
      out_slot_r <= pend_slot_r;
      out_last_r <= push_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = ott_pkg::slot_id_t'(out_slot_r);
  assign out_last         = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ott_pkg::slot_cnt_t'(ott_pkg::SLOTS))
    else $error("armed count beyond table size");

  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= rd_r)
    else $error("compaction pointer ahead of read pointer");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> ($countones(armed_r) == int'(cnt_r)))
    else $error("queue length differs from armed slots");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.at_end)
    else $error("walk stepped past the queue end");

endmodule

`default_nettype wire
